@@ hw/rtl/coin_credit_io_controller_macros.svh @@
// Assertion macros for the coin and credit I/O controller.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef COIN_CREDIT_IO_CONTROLLER_MACROS_SVH
`define COIN_CREDIT_IO_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CCI_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("cci: same-cycle check failed");
// Next-cycle implication
`define CCI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cci: next-cycle check failed");
`else
`define CCI_ASSERT_SAME(label, pre, post)
`define CCI_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ hw/rtl/cci_pkg.sv @@
// Shared types, codes and helpers of the coin and credit I/O controller.
// No dependencies; used by the input channel interface and the top level.
package cci_pkg;

  // Bus operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FRAME = 2'd2,
    OP_RESET = 2'd3
  } op_e;

  // Frame command codes held in the command word
  localparam logic [3:0] CMD_NOP     = 4'd0;
  localparam logic [3:0] CMD_DIRECT  = 4'd1;
  localparam logic [3:0] CMD_COINAGE = 4'd2;
  localparam logic [3:0] CMD_CREDIT  = 4'd3;
  localparam logic [3:0] CMD_MUX     = 4'd4;
  localparam logic [3:0] CMD_BOOT    = 4'd5;

  // Shared RAM layout
  localparam logic [3:0] WORD_CMD  = 4'd8;
  localparam logic [3:0] WORD_CFG  = 4'd9;
  localparam logic [3:0] WORD_BASE = 4'd4;

  // Credit reporting
  localparam logic [3:0] BCD_SWAP      = 4'd2;
  localparam logic [6:0] CREDIT_MAX    = 7'd99;
  localparam logic [7:0] BCD_RECIP     = 8'd205;
  localparam int         BCD_SHIFT     = 11;
  localparam logic [6:0] DEC_BASE      = 7'd10;
  localparam logic [3:0] COINAGE_RESET = 4'd1;
  localparam logic [3:0] BTN_PAIR_LO   = 4'h5;
  localparam logic [3:0] BTN_PAIR_HI   = 4'hA;

  // Boot check
  localparam logic [7:0] LFSR_TAP  = 8'h90;
  localparam logic [6:0] LFSR_SEED = 7'h22;

  typedef logic [15:0] ram_vld_t;

  // One step of the 7-bit boot-check LFSR
  function automatic logic [6:0] lfsr_next(input logic [6:0] v);
    logic [7:0] t;
    t = {1'b0, v} ^ (v[0] ? LFSR_TAP : 8'h00);
    return t[7:1];
  endfunction

  // Boot-check word order, as offsets from the first coinage word
  function automatic logic [2:0] boot_order(input logic [2:0] j);
    logic [2:0] r;
    case (j)
      3'd0: r = 3'd2;
      3'd1: r = 3'd1;
      3'd2: r = 3'd0;
      3'd3: r = 3'd6;
      3'd4: r = 3'd5;
      3'd5: r = 3'd4;
      3'd6: r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/cci_in_if.sv @@
// Input channel of the coin and credit I/O controller: one bus word per item.
// Depends on cci_pkg for the operation type.
interface cci_in_if;
  logic            valid;
  logic            ready;
  cci_pkg::op_e    op;
  logic [3:0]      addr;
  logic [3:0]      wdata;
  logic [3:0]      coin_port;
  logic [3:0]      p1_port;
  logic [3:0]      p2_port;
  logic [3:0]      button_port;

  modport source (
    output valid, op, addr, wdata, coin_port, p1_port, p2_port, button_port,
    input  ready
  );
  modport sink (
    input  valid, op, addr, wdata, coin_port, p1_port, p2_port, button_port,
    output ready
  );
endinterface

@@ hw/rtl/cci_out_if.sv @@
// Output channel of the coin and credit I/O controller: one read word per item.
// No dependencies.
interface cci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;

  modport source (output valid, rdata, input ready);
  modport sink (input valid, rdata, output ready);
endinterface

@@ hw/rtl/coin_credit_io_controller.sv @@
// Coin and credit I/O controller. Every input word returns exactly one output word: a bus
// read returns 0xF0 or'ed with the addressed shared RAM nibble, all other operations
// return zero. A bus read passes through one registered RAM read. A frame command first
// fetches the command word, then runs a nop, direct read, coinage, multiplexed read,
// credit mode or the boot check, whose LFSR advance count N (0..127) is taken from words 9
// and 10; the boot check is bounded by its single shared LFSR step unit, which advances
// once per cycle, and the direct, multiplexed and credit commands by the one write port
// of the shared RAM. The block takes a new word only when the previous one is finished;
// a finished result may still be waiting in the output register. Reset and the chip reset
// op clear the shared RAM at once through per-word valid bits.
// Depends on cci_pkg, cci_in_if, cci_out_if and coin_credit_io_controller_macros.svh.
`include "coin_credit_io_controller_macros.svh"

module coin_credit_io_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  cci_in_if.sink      in_i,
  cci_out_if.source   out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMD,
    ST_CFG,
    ST_CR_COIN,
    ST_CR_SUM,
    ST_WR,
    ST_BC_LOAD,
    ST_BC_ADV,
    ST_BC_MIX,
    ST_BC_FIN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [3:0]          mem_q [16];
  cci_pkg::ram_vld_t   vld_q;
  logic [3:0]          rd_data_q;
  logic                rd_vld_q;
  logic [3:0][3:0]     port_q;
  logic [3:0]          cmd_q;
  logic [2:0]          step_q;
  logic [2:0]          row_q;
  logic [7:0]          res_q;
  logic                out_vld_q;
  logic [7:0]          out_data_q;
  logic [3:0]          last_coin_q;
  logic [3:0]          last_btn_q;
  logic [3:0]          coin_edge_q;
  logic [3:0]          btn_edge_q;
  logic [6:0]          credit_q;
  logic [1:0][3:0]     coin_cnt_q;
  logic [1:0][3:0]     cpc_q;
  logic [1:0][3:0]     cpk_q;
  logic [4:0]          add_q;
  logic [1:0]          sub_q;
  logic                lock_q;
  logic [6:0][3:0]     bc_w_q;
  logic [6:0]          cnt_q;
  logic [6:0]          seed_q;
  logic [6:0]          rng_q;
  logic [3:0]          acc_q;

  logic                accept;
  logic [3:0]          rd_addr;
  logic [3:0]          rd_val;
  logic                mem_we;
  logic [3:0]          mem_wa;
  logic [3:0]          mem_wd;
  logic                wr_last;
  logic [14:0]         bcd_prod;
  logic [3:0]          tens;
  logic [6:0]          units_w;
  logic [3:0]          word5;
  logic [3:0]          word7;
  logic                k_sel;
  logic [3:0]          coin_inc;
  logic [2:0]          coin_need;
  logic                coin_hit;
  logic [4:0]          coin_add;
  logic [4:0]          add_eff;
  logic [1:0]          sub_c;
  logic signed [8:0]   total;
  logic [6:0]          total_sat;
  logic [6:0]          lfsr_in;
  logic [6:0]          lfsr_out;
  logic [6:0]          rng_cur;
  logic [3:0]          acc_n;
  logic                out_free;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.rdata = out_data_q;
  assign out_free    = !out_vld_q || out_o.ready;
  assign rd_val      = rd_vld_q ? rd_data_q : 4'h0;

  // Pick the RAM read address for the registered read whose data is used in the next cycle
  always_comb begin
    case (state_q)
      ST_IDLE:    rd_addr = (in_i.op == cci_pkg::OP_READ) ? in_i.addr : cci_pkg::WORD_CMD;
      ST_CMD:     rd_addr = cci_pkg::WORD_CFG;
      ST_CFG,
      ST_BC_LOAD: rd_addr = cci_pkg::WORD_CFG + {1'b0, step_q} + 4'd1;
      default:    rd_addr = cci_pkg::WORD_CMD;
    endcase
  end

  // Convert the credit count to BCD by reciprocal multiply
  assign bcd_prod = 15'(credit_q) * 15'(cci_pkg::BCD_RECIP);
  assign tens     = bcd_prod[14:cci_pkg::BCD_SHIFT];
  assign units_w  = credit_q - ({3'b000, tens} * cci_pkg::DEC_BASE);

  // Button level and edge report words
  assign word5 = ((port_q[3] & cci_pkg::BTN_PAIR_LO) << 1) | (btn_edge_q & cci_pkg::BTN_PAIR_LO);
  assign word7 = (port_q[3] & cci_pkg::BTN_PAIR_HI) | ((btn_edge_q & cci_pkg::BTN_PAIR_HI) >> 1);

  // Coin slot unit, shared by both slots
  assign k_sel     = step_q[0];
  assign coin_inc  = coin_cnt_q[k_sel] + 4'd1;
  assign coin_need = cpc_q[k_sel][2:0];
  assign coin_hit  = coin_inc >= {1'b0, coin_need};
  assign coin_add  = {1'b0, cpk_q[k_sel]} - {4'b0000, cpc_q[k_sel][3]};

  // Credit total with saturation; start1 wins over start2
  always_comb begin
    add_eff = coin_edge_q[3] ? 5'd1 : add_q;
    sub_c   = 2'd0;
    if (lock_q) begin
      if (btn_edge_q[2]) begin
        sub_c = (credit_q >= 7'd1) ? 2'd1 : 2'd0;
      end else if (btn_edge_q[3]) begin
        sub_c = (credit_q >= 7'd2) ? 2'd2 : 2'd0;
      end
    end
    total = $signed({2'b00, credit_q}) + $signed({{4{add_eff[4]}}, add_eff})
          - $signed({7'b0000000, sub_c});
    if (total < 0) begin
      total_sat = 7'd0;
    end else if (total > $signed({2'b00, cci_pkg::CREDIT_MAX})) begin
      total_sat = cci_pkg::CREDIT_MAX;
    end else begin
      total_sat = total[6:0];
    end
  end

  // Shared LFSR step unit for the advance and mix phases
  assign lfsr_in  = (state_q == ST_BC_ADV) ? seed_q : rng_q;
  assign lfsr_out = cci_pkg::lfsr_next(lfsr_in);
  assign rng_cur  = (step_q == 3'd0) ? seed_q : lfsr_out;
  assign acc_n    = acc_q ^ (rng_cur[0] ? ~bc_w_q[cci_pkg::boot_order(step_q)] : 4'h0);

  // Drive the single RAM write port
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = in_i.addr;
    mem_wd  = in_i.wdata;
    wr_last = (step_q == 3'd7);
    case (state_q)
      ST_IDLE: begin
        mem_we = accept && (in_i.op == cci_pkg::OP_WRITE);
      end
      ST_WR: begin
        mem_we = 1'b1;
        case (cmd_q)
          cci_pkg::CMD_DIRECT: begin
            mem_wa  = cci_pkg::WORD_BASE + {2'b00, step_q[1:0]};
            mem_wd  = port_q[step_q[1:0]];
            wr_last = (step_q == 3'd3);
          end
          cci_pkg::CMD_MUX: begin
            mem_wa = {1'b0, step_q};
            mem_wd = port_q[step_q[2:1]];
          end
          default: begin
            // credit report
            if (!step_q[2]) begin
              mem_wa = {2'b00, step_q[1:0]} ^ cci_pkg::BCD_SWAP;
            end else begin
              mem_wa = {1'b0, step_q};
            end
            case (step_q)
              3'd0: mem_wd = tens;
              3'd1: mem_wd = units_w[3:0];
              3'd2: begin
                mem_wd = add_q[3:0];
                mem_we = (add_q != 5'd0);
              end
              3'd3: begin
                mem_wd = {2'b00, sub_q};
                mem_we = (sub_q != 2'd0);
              end
              3'd4: mem_wd = port_q[1];
              3'd5: mem_wd = word5;
              3'd6: mem_wd = port_q[2];
              default: mem_wd = word7;
            endcase
          end
        endcase
      end
      ST_BC_MIX: begin
        mem_we = (step_q == 3'd6);
        mem_wa = {1'b0, row_q};
        mem_wd = ~acc_n;
      end
      ST_BC_FIN: begin
        mem_we = 1'b1;
        mem_wa = 4'd0;
        mem_wd = (bc_w_q[0] == 4'hF) ? 4'hF : 4'h0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Shared RAM array with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer, state registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      port_q      <= '0;
      cmd_q       <= cci_pkg::CMD_NOP;
      step_q      <= '0;
      row_q       <= '0;
      res_q       <= '0;
      out_vld_q   <= 1'b0;
      out_data_q  <= '0;
      last_coin_q <= '0;
      last_btn_q  <= '0;
      coin_edge_q <= '0;
      btn_edge_q  <= '0;
      credit_q    <= '0;
      coin_cnt_q  <= '0;
      cpc_q       <= {2{cci_pkg::COINAGE_RESET}};
      cpk_q       <= {2{cci_pkg::COINAGE_RESET}};
      add_q       <= '0;
      sub_q       <= '0;
      lock_q      <= 1'b0;
      bc_w_q      <= '0;
      cnt_q       <= '0;
      seed_q      <= cci_pkg::LFSR_SEED;
      rng_q       <= '0;
      acc_q       <= '0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      // drop the output word once taken, unless a new one is loaded now
      if (out_vld_q && out_o.ready && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            port_q <= {~in_i.button_port, ~in_i.p2_port, ~in_i.p1_port, ~in_i.coin_port};
            res_q  <= '0;
            step_q <= '0;
            case (in_i.op)
              cci_pkg::OP_READ:  state_q <= ST_RD;
              cci_pkg::OP_FRAME: state_q <= ST_CMD;
              cci_pkg::OP_RESET: begin
                vld_q       <= '0;
                last_coin_q <= '0;
                last_btn_q  <= '0;
                credit_q    <= '0;
                coin_cnt_q  <= '0;
                cpc_q       <= {2{cci_pkg::COINAGE_RESET}};
                cpk_q       <= {2{cci_pkg::COINAGE_RESET}};
                state_q     <= ST_DONE;
              end
              default:           state_q <= ST_DONE;
            endcase
          end
        end

        ST_RD: begin
          res_q   <= {4'hF, rd_val};
          state_q <= ST_DONE;
        end

        // dispatch on the command word
        ST_CMD: begin
          cmd_q <= rd_val;
          case (rd_val)
            cci_pkg::CMD_DIRECT,
            cci_pkg::CMD_MUX:     state_q <= ST_WR;
            cci_pkg::CMD_COINAGE: state_q <= ST_CFG;
            cci_pkg::CMD_CREDIT: begin
              coin_edge_q <= port_q[0] & ~last_coin_q;
              last_coin_q <= port_q[0];
              btn_edge_q  <= port_q[3] & ~last_btn_q;
              last_btn_q  <= port_q[3];
              add_q       <= '0;
              state_q     <= ST_CR_COIN;
            end
            cci_pkg::CMD_BOOT:    state_q <= ST_BC_LOAD;
            default:              state_q <= ST_DONE;
          endcase
        end

        // load coinage words 9..12
        ST_CFG: begin
          case (step_q[1:0])
            2'd0: cpc_q[0] <= rd_val;
            2'd1: cpk_q[0] <= rd_val;
            2'd2: cpc_q[1] <= rd_val;
            default: cpk_q[1] <= rd_val;
          endcase
          step_q <= step_q + 3'd1;
          if (step_q == 3'd3) begin
            state_q <= ST_DONE;
          end
        end

        // one coin slot per cycle; a later event replaces the add value
        ST_CR_COIN: begin
          if (step_q == 3'd0) begin
            lock_q <= (rd_val == 4'h0);
          end
          if (coin_edge_q[k_sel]) begin
            if (coin_hit) begin
              add_q             <= coin_add;
              coin_cnt_q[k_sel] <= coin_inc - {1'b0, coin_need};
            end else begin
              coin_cnt_q[k_sel] <= coin_inc;
              if (cpc_q[k_sel][3]) begin
                add_q <= 5'd1;
              end
            end
          end
          step_q <= step_q + 3'd1;
          if (step_q == 3'd1) begin
            state_q <= ST_CR_SUM;
          end
        end

        ST_CR_SUM: begin
          credit_q <= total_sat;
          add_q    <= add_eff;
          sub_q    <= sub_c;
          step_q   <= '0;
          state_q  <= ST_WR;
        end

        ST_WR: begin
          step_q <= step_q + 3'd1;
          if (wr_last) begin
            state_q <= ST_DONE;
          end
        end

        // load words 9..15 for the boot check
        ST_BC_LOAD: begin
          bc_w_q[step_q] <= rd_val;
          step_q         <= step_q + 3'd1;
          if (step_q == 3'd6) begin
            cnt_q   <= {bc_w_q[0][2:0], bc_w_q[1]};
            seed_q  <= cci_pkg::LFSR_SEED;
            state_q <= ST_BC_ADV;
          end
        end

        // advance the seed once per cycle
        ST_BC_ADV: begin
          if (cnt_q == 7'd0) begin
            step_q  <= '0;
            row_q   <= 3'd1;
            acc_q   <= '0;
            state_q <= ST_BC_MIX;
          end else begin
            seed_q <= lfsr_out;
            cnt_q  <= cnt_q - 7'd1;
          end
        end

        // one mix step per cycle, seven per output word
        ST_BC_MIX: begin
          rng_q <= rng_cur;
          if (step_q == 3'd1) begin
            seed_q <= rng_cur;
          end
          if (step_q == 3'd6) begin
            step_q <= '0;
            acc_q  <= '0;
            row_q  <= row_q + 3'd1;
            if (row_q == 3'd7) begin
              state_q <= ST_BC_FIN;
            end
          end else begin
            step_q <= step_q + 3'd1;
            acc_q  <= acc_n;
          end
        end

        ST_BC_FIN: begin
          state_q <= ST_DONE;
        end

        // hand the result to the output register
        ST_DONE: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_data_q <= res_q;
            state_q    <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Credits never leave the BCD range
  `CCI_ASSERT_SAME(a_credit_range, 1'b1, credit_q <= cci_pkg::CREDIT_MAX)
  // Chip reset clears the credit and coin counters
  `CCI_ASSERT_NEXT(a_chip_reset, accept && (in_i.op == cci_pkg::OP_RESET), (credit_q == 7'd0) && (coin_cnt_q == '0))
  // A bus write marks its word valid
  `CCI_ASSERT_NEXT(a_write_valid, accept && (in_i.op == cci_pkg::OP_WRITE), vld_q[$past(in_i.addr)])
  // A bus read result has the high nibble set
  `CCI_ASSERT_NEXT(a_read_high, state_q == ST_RD, res_q[7:4] == 4'hF)

endmodule

@@ tb/sv/cci_word_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the coin and credit I/O controller: keeps its own copy of the chip state,
// predicts the read word of every accepted bus word and compares the returned words in order.
// Depends on cci_pkg, cci_in_if and cci_out_if.
module cci_word_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cci_in_if    in_mon,
  cci_out_if   out_mon,
  output int   mismatch_count_o,
  output int   pending_o
);
  import cci_pkg::*;

  // Credit report placement before the nibble swap
  localparam logic [3:0] WORD_TENS   = 4'd0;
  localparam logic [3:0] WORD_UNITS  = 4'd1;
  localparam logic [3:0] WORD_ADD    = 4'd2;
  localparam logic [3:0] WORD_SUB    = 4'd3;
  localparam logic [3:0] CREDIT_SWAP = 4'd2;
  // Port words written by credit mode
  localparam logic [3:0] WORD_P1     = 4'd4;
  localparam logic [3:0] WORD_BTN_A  = 4'd5;
  localparam logic [3:0] WORD_P2     = 4'd6;
  localparam logic [3:0] WORD_BTN_B  = 4'd7;
  localparam int         CREDIT_CAP  = 99;
  // Boot checksum
  localparam logic [7:0] TAP_MASK    = 8'h90;
  localparam logic [6:0] BOOT_SEED   = 7'h22;
  localparam logic [3:0] WORD_STEPS  = WORD_CFG + 4'd1;
  // Words folded into the checksum, first tap in the low nibble
  localparam logic [27:0] BOOT_TAPS  = {4'd12, 4'd13, 4'd14, 4'd15, 4'd9, 4'd10, 4'd11};

  logic [3:0] ram_m [16];
  logic [3:0] coin_lvl;
  logic [3:0] button_lvl;
  logic [6:0] credits;
  logic [3:0] coin_cnt [2];
  logic [3:0] coin_price [2];  // coins per credit, bit 3 selects the bonus mode
  logic [3:0] coin_value [2];  // credits granted when the price is met, less one in bonus mode
  logic [7:0] rdata_q [$];
  logic [7:0] rdata_exp;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("[%0t] rdata mismatch (%s): expected %02h, got %02h", $time, what, want, got);
    mismatch_count_o++;
  endtask

  function automatic void clear_chip();
    int i;
    for (i = 0; i < 16; i++) ram_m[i] = 4'h0;
    coin_lvl   = 4'h0;
    button_lvl = 4'h0;
    credits    = 7'd0;
    for (i = 0; i < 2; i++) begin
      coin_cnt[i]   = 4'h0;
      coin_price[i] = 4'h1;
      coin_value[i] = 4'h1;
    end
  endfunction

  function automatic logic [6:0] lfsr_step(input logic [6:0] v);
    logic [7:0] t;
    t = {1'b0, v};
    if (v[0]) t = t ^ TAP_MASK;
    return t[7:1];
  endfunction

  // Coin, service and start counting with BCD credit report
  function automatic void run_credit(input logic [3:0] coin_n, input logic [3:0] p1_n,
                                     input logic [3:0] p2_n, input logic [3:0] btn_n);
    int add, sub, total, k;
    logic [3:0] lvl, rise, need;
    add  = 0;
    sub  = 0;
    lvl  = ~coin_n;
    rise = lvl & (lvl ^ coin_lvl);
    coin_lvl = lvl;
    for (k = 0; k < 2; k++) begin
      if (rise[k]) begin
        need = {1'b0, coin_price[k][2:0]};
        coin_cnt[k] = coin_cnt[k] + 4'd1;
        if (coin_cnt[k] >= need) begin
          // later coin slot overrides the add value, never accumulates
          add = int'(coin_value[k]) - int'(coin_price[k][3]);
          coin_cnt[k] = coin_cnt[k] - need;
        end else if (coin_price[k][3]) begin
          add = 1;
        end
      end
    end
    if (rise[3]) add = 1;

    lvl  = ~btn_n;
    rise = lvl & (lvl ^ button_lvl);
    button_lvl = lvl;
    // Starts only count while the config word is clear; start1 wins
    if (ram_m[WORD_CFG] == 4'h0) begin
      if (rise[2]) begin
        if (credits >= 7'd1) sub = 1;
      end else if (rise[3]) begin
        if (credits >= 7'd2) sub = 2;
      end
    end

    total = int'(credits) + add - sub;
    if (total < 0) total = 0;
    if (total > CREDIT_CAP) total = CREDIT_CAP;
    credits = 7'(total);

    ram_m[WORD_TENS ^ CREDIT_SWAP]  = 4'(total / 10);
    ram_m[WORD_UNITS ^ CREDIT_SWAP] = 4'(total % 10);
    if (add != 0) ram_m[WORD_ADD ^ CREDIT_SWAP] = add[3:0];
    if (sub != 0) ram_m[WORD_SUB ^ CREDIT_SWAP] = sub[3:0];

    ram_m[WORD_P1]    = ~p1_n;
    ram_m[WORD_BTN_A] = {lvl[2], rise[2], lvl[0], rise[0]};
    ram_m[WORD_P2]    = ~p2_n;
    ram_m[WORD_BTN_B] = {lvl[3], rise[3], lvl[1], rise[1]};
  endfunction

  // LFSR checksum over the config words into words 1..7, with word 0 set from the config word
  function automatic void run_boot();
    logic [6:0] seed, rng;
    logic [3:0] acc;
    int steps, i, j;
    seed  = BOOT_SEED;
    steps = int'({ram_m[WORD_CFG][2:0], ram_m[WORD_STEPS]});
    for (i = 0; i < steps; i++) seed = lfsr_step(seed);
    for (i = 1; i < 8; i++) begin
      acc = 4'h0;
      rng = seed;
      for (j = 0; j < 7; j++) begin
        if (j > 0) rng = lfsr_step(rng);
        if (j == 1) seed = rng;
        if (rng[0]) acc = acc ^ ~ram_m[BOOT_TAPS[j*4 +: 4]];
      end
      ram_m[i] = ~acc;
    end
    ram_m[0] = (ram_m[WORD_CFG] == 4'hF) ? 4'hF : 4'h0;
  endfunction

  // Advance the mirrored chip by one bus word and return its read word
  function automatic logic [7:0] predict_word(input op_e op, input logic [3:0] addr,
                                              input logic [3:0] wdata,
                                              input logic [3:0] coin_n,
                                              input logic [3:0] p1_n,
                                              input logic [3:0] p2_n,
                                              input logic [3:0] btn_n);
    logic [7:0] rd;
    int n;
    logic [15:0] ports;
    rd = 8'h00;
    ports = {btn_n, p2_n, p1_n, coin_n};
    case (op)
      OP_WRITE: ram_m[addr] = wdata;
      OP_READ:  rd = {4'hF, ram_m[addr]};
      OP_RESET: clear_chip();
      default: begin
        case (ram_m[WORD_CMD])
          CMD_DIRECT: begin
            for (n = 0; n < 4; n++) ram_m[WORD_BASE + 4'(n)] = ~ports[n*4 +: 4];
          end
          CMD_COINAGE: begin
            coin_price[0] = ram_m[WORD_CFG];
            coin_value[0] = ram_m[WORD_CFG + 4'd1];
            coin_price[1] = ram_m[WORD_CFG + 4'd2];
            coin_value[1] = ram_m[WORD_CFG + 4'd3];
          end
          CMD_CREDIT: run_credit(coin_n, p1_n, p2_n, btn_n);
          CMD_MUX: begin
            // both halves of each pair see the same port
            for (n = 0; n < 4; n++) begin
              ram_m[2*n]     = ~ports[n*4 +: 4];
              ram_m[2*n + 1] = ~ports[n*4 +: 4];
            end
          end
          CMD_BOOT: run_boot();
          default: ;
        endcase
      end
    endcase
    return rd;
  endfunction

  // Compare returned words first, then queue the prediction for the accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_chip();
      rdata_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (rdata_q.size() == 0) begin
          report_mismatch("no word expected", 8'h00, out_mon.rdata);
        end else begin
          rdata_exp = rdata_q.pop_front();
          if (out_mon.rdata !== rdata_exp) report_mismatch("rdata", rdata_exp, out_mon.rdata);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        rdata_q.push_back(predict_word(in_mon.op, in_mon.addr, in_mon.wdata, in_mon.coin_port,
                                       in_mon.p1_port, in_mon.p2_port, in_mon.button_port));
      end
      pending_o <= rdata_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the coin and credit I/O controller testbench: clock, reset, bus word stimulus,
// receiver stalls and the verdict. Depends on cci_pkg, the channel interfaces and cci_word_checker.
module tb_top;
  import cci_pkg::*;

  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         ITEM_TARGET  = 550;
  localparam int         LONG_HOLD    = 400;
  localparam int         DRAIN_CYCLES = 300;
  localparam logic [3:0] CMD_SPARE_LO = 4'd6;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   words_pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   words_sent;
  int   cycle_count;
  logic hold_go;

  cci_in_if  in_if ();
  cci_out_if out_if ();

  coin_credit_io_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cci_word_checker u_word_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_if),
    .out_mon          (out_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold-off once requested
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [3:0] rnd4();
    return 4'($urandom_range(15));
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input op_e op, input logic [3:0] addr, input logic [3:0] wdata,
                           input logic [3:0] coin_n, input logic [3:0] p1_n,
                           input logic [3:0] p2_n, input logic [3:0] btn_n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.addr        <= addr;
    in_if.wdata       <= wdata;
    in_if.coin_port   <= coin_n;
    in_if.p1_port     <= p1_n;
    in_if.p2_port     <= p2_n;
    in_if.button_port <= btn_n;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic bus_write(input logic [3:0] addr, input logic [3:0] data);
    send_word(OP_WRITE, addr, data, rnd4(), rnd4(), rnd4(), rnd4());
  endtask

  task automatic bus_read(input logic [3:0] addr);
    send_word(OP_READ, addr, rnd4(), rnd4(), rnd4(), rnd4(), rnd4());
  endtask

  task automatic frame_cmd(input logic [3:0] coin_n, input logic [3:0] p1_n,
                           input logic [3:0] p2_n, input logic [3:0] btn_n);
    send_word(OP_FRAME, rnd4(), rnd4(), coin_n, p1_n, p2_n, btn_n);
  endtask

  initial begin
    int phase, n, k, kind, stop_at;
    logic rush;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_WRITE;
    in_if.addr        <= 4'h0;
    in_if.wdata       <= 4'h0;
    in_if.coin_port   <= 4'hF;
    in_if.p1_port     <= 4'hF;
    in_if.p2_port     <= 4'hF;
    in_if.button_port <= 4'hF;
    send_idle_pct     <= 16;
    recv_idle_pct     <= 55;
    hold_go           <= 1'b0;
    words_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset contents and the top address
    bus_read(4'd0);
    bus_write(4'd15, 4'hF);
    bus_read(4'd15);
    // Direct read with every port pressed, multiplexed read with none
    bus_write(WORD_CMD, CMD_DIRECT);
    frame_cmd(4'h0, 4'h0, 4'h0, 4'h0);
    bus_read(4'd7);
    bus_write(WORD_CMD, CMD_MUX);
    frame_cmd(4'hF, 4'hF, 4'hF, 4'hF);
    bus_read(4'd1);
    // Boot check with the longest LFSR advance and an all-ones config word
    bus_write(WORD_CFG, 4'hF);
    bus_write(WORD_CFG + 4'd1, 4'hF);
    bus_write(WORD_CMD, CMD_BOOT);
    frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
    bus_read(4'd0);
    // Undefined command does nothing
    bus_write(WORD_CMD, CMD_SPARE_HI);
    frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
    // Bonus price with zero value: a coin subtracts, count clamps at zero
    bus_write(WORD_CFG, 4'h8);
    bus_write(WORD_CFG + 4'd1, 4'h0);
    bus_write(WORD_CMD, CMD_COINAGE);
    frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
    bus_write(WORD_CMD, CMD_CREDIT);
    frame_cmd(4'hE, 4'h5, 4'hA, 4'hF);
    bus_read(4'd0);
    // Chip reset op
    send_word(OP_RESET, rnd4(), rnd4(), rnd4(), rnd4(), rnd4(), rnd4());
    bus_read(4'd2);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 16;
          recv_idle_pct <= 55;
        end
        1: begin
          send_idle_pct <= 55;
          recv_idle_pct <= 16;
        end
        default: begin
          // no idling; the receiver holds off once so the block backs up
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
          hold_go       <= 1'b1;
        end
      endcase
      stop_at = words_sent + ITEM_TARGET / 3;
      while (words_sent < stop_at) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          // Credit session, optionally with a fresh coinage set-up
          if ($urandom_range(1) != 0) begin
            for (k = 0; k < 4; k++) bus_write(WORD_CFG + 4'(k), rnd4());
            bus_write(WORD_CMD, CMD_COINAGE);
            frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
          end
          bus_write(WORD_CFG, ($urandom_range(2) != 0) ? 4'h0 : rnd4());
          bus_write(WORD_CMD, CMD_CREDIT);
          rush = ($urandom_range(3) == 0);
          n = $urandom_range(12, 4);
          for (k = 0; k < n; k++) begin
            // a rush toggles both coin slots every other frame to push toward the cap
            if (rush) frame_cmd(k[0] ? 4'hF : 4'hC, rnd4(), rnd4(), 4'hF);
            else frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
            if ($urandom_range(1) != 0) bus_read(4'($urandom_range(7)));
          end
        end else if (kind < 50) begin
          // Port scan, direct or multiplexed
          bus_write(WORD_CMD, ($urandom_range(1) != 0) ? CMD_DIRECT : CMD_MUX);
          frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
          n = $urandom_range(4, 1);
          for (k = 0; k < n; k++) bus_read(4'($urandom_range(7)));
        end else if (kind < 60) begin
          // Boot check over random config words
          bus_write(WORD_CFG, ($urandom_range(3) == 0) ? 4'hF : rnd4());
          for (k = 1; k < 7; k++) bus_write(WORD_CFG + 4'(k), rnd4());
          bus_write(WORD_CMD, CMD_BOOT);
          frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
          for (k = 0; k < 8; k++) bus_read(4'(k));
        end else if (kind < 70) begin
          // Nop or undefined command
          bus_write(WORD_CMD, ($urandom_range(3) == 0) ? CMD_NOP :
                    4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)));
          frame_cmd(rnd4(), rnd4(), rnd4(), rnd4());
          bus_read(rnd4());
        end else begin
          // Noise: any op on any address, with an occasional chip reset
          n = $urandom_range(6, 1);
          for (k = 0; k < n; k++) begin
            send_word(($urandom_range(19) == 0) ? OP_RESET : op_e'($urandom_range(2)),
                      rnd4(), rnd4(), rnd4(), rnd4(), rnd4(), rnd4());
          end
        end
      end
    end
    in_if.valid <= 1'b0;

    // Drain outstanding words, then give stray words time to show up
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cci_pkg.sv
hw/rtl/cci_in_if.sv
hw/rtl/cci_out_if.sv
hw/rtl/coin_credit_io_controller.sv
tb/sv/cci_word_checker.sv
tb/sv/tb_top.sv
